// ===== src/jpeg_app1_signature_scanner_macros.svh =====
// Assertion macros for the signature scanner checker
`ifndef JPEG_APP1_SIGNATURE_SCANNER_MACROS_SVH
`define JPEG_APP1_SIGNATURE_SCANNER_MACROS_SVH

// Check that a condition implies another in the same cycle
`define JAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner check failed: same-cycle implication");

// Check that a condition implies another in the following cycle
`define JAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner check failed: next-cycle implication");

`endif

// ===== src/jas_pkg.sv =====
// Types and constants for the JPEG APP1 signature scanner
`timescale 1ns / 1ps

package jas_pkg;

    localparam int SIG_LEN   = 14;
    localparam int WIN_DEPTH = 15;

    localparam logic [7:0] BYTE_MARK = 8'hFF;
    localparam logic [7:0] BYTE_SOI  = 8'hD8;
    localparam logic [7:0] BYTE_APP1 = 8'hE1;

    // "hdrgm:Version=" in file order
    localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
        8'h68, 8'h64, 8'h72, 8'h67, 8'h6D, 8'h3A, 8'h56,
        8'h65, 8'h72, 8'h73, 8'h69, 8'h6F, 8'h6E, 8'h3D
    };

    typedef enum logic [3:0] {
        PH_SOI0,
        PH_SOI1,
        PH_FF_FIRST,
        PH_MK_FIRST,
        PH_FF,
        PH_MK,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_FOUND,
        ST_NO_SOI,
        ST_STOPPED,
        ST_NO_MATCH
    } status_t;

    // Control from the segment walker to the signature window
    typedef struct packed {
        logic clear;
        logic shift;
    } win_ctrl_t;

endpackage

// ===== src/jas_sig_window.sv =====
// Sliding byte window over APP1 data with the signature compare
`timescale 1ns / 1ps

module jas_sig_window
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data_byte,
    input  jas_pkg::win_ctrl_t  ctrl,
    output logic                hit
);
    import jas_pkg::*;

    localparam int OFS_W = $clog2(WIN_DEPTH + 1);

    logic [7:0]       win_reg [WIN_DEPTH];
    logic [OFS_W-1:0] offset_reg;
    logic [OFS_W-1:0] offset_next;
    logic             full;
    logic             sig_eq;

    assign full = (offset_reg == OFS_W'(WIN_DEPTH));

    // Compare the older bytes of the window with the signature
    always_comb
    begin
        sig_eq = 1'b1;
        for (int i = 0; i < SIG_LEN; i++)
        begin
            if (win_reg[WIN_DEPTH - 1 - i] != SIG_BYTES[i])
            begin
                sig_eq = 1'b0;
            end
        end
    end

    assign hit = full && sig_eq;

    // Advance the fill count, clearing it on clear and saturating once the window is full
    always_comb
    begin
        offset_next = offset_reg;
        if (ctrl.clear)
        begin
            offset_next = '0;
        end
        else if (ctrl.shift && !full)
        begin
            offset_next = offset_reg + OFS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
        end
    end

    // Shift the newest byte in at the front
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            win_reg[0] <= data_byte;
            for (int k = 1; k < WIN_DEPTH; k++)
            begin
                win_reg[k] <= win_reg[k - 1];
            end
        end
    end

endmodule

// ===== src/jpeg_app1_signature_scanner.sv =====
// Top level of the JPEG APP1 signature scanner
`timescale 1ns / 1ps

// Scans a JPEG file fed as one byte per item (tlast on the final byte) and
// returns a single verdict item when the final byte has been processed:
// found in bit 0 and the status code in bits 2:1 of m_tdata (0 found, 1 no
// JPEG start, 2 scan stopped, 3 ended without match). One byte is taken per
// clock cycle while the verdict output is not stalled. The final byte passes
// through the input register, then the segment walker and the 14-byte window
// compare load the verdict into the result register. The input side keeps
// accepting while a verdict waits to be taken, until the input register is
// also occupied. All scan state returns to its reset values after each
// verdict, so files may follow one another without a gap.
module jpeg_app1_signature_scanner
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] found, [2:1] status, [7:3] zero
);
    import jas_pkg::*;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Scan state
    phase_t     phase_reg,   phase_next;
    status_t    stop_reg,    stop_next;
    logic [15:0] left_reg,   left_next;
    logic [7:0] lenhi_reg,   lenhi_next;
    logic       app1_reg,    app1_next;
    logic       open_reg,    open_next;

    // Result register
    logic       out_valid_reg;
    logic       found_reg;
    status_t    status_reg;
    status_t    status_next;

    logic       advance;
    logic       proc;
    logic       win_hit;
    win_ctrl_t  win_ctrl;
    logic       header_early;

    assign advance  = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, status_reg, found_reg};

    jas_sig_window u_window
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (in_byte_reg),
        .ctrl      (win_ctrl),
        .hit       (win_hit)
    );

    // Hold the accepted item until the walker takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    assign header_early = phase_reg inside {PH_SOI0, PH_SOI1, PH_FF_FIRST, PH_MK_FIRST};

    // Walk the marker segments and form the verdict on the final byte
    always_comb
    begin
        phase_next  = phase_reg;
        stop_next   = stop_reg;
        left_next   = left_reg;
        lenhi_next  = lenhi_reg;
        app1_next   = app1_reg;
        open_next   = open_reg;
        win_ctrl    = '0;
        status_next = ST_NO_MATCH;

        if (proc)
        begin
            case (phase_reg)
                PH_SOI0:
                begin
                    if (in_byte_reg == BYTE_MARK)
                    begin
                        phase_next = PH_SOI1;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                        stop_next  = ST_NO_SOI;
                    end
                end
                PH_SOI1:
                begin
                    if (in_byte_reg == BYTE_SOI)
                    begin
                        phase_next = PH_FF_FIRST;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                        stop_next  = ST_NO_SOI;
                    end
                end
                PH_FF_FIRST, PH_FF:
                begin
                    if (in_byte_reg == BYTE_MARK)
                    begin
                        phase_next = (phase_reg == PH_FF_FIRST) ? PH_MK_FIRST : PH_MK;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                        stop_next  = ST_STOPPED;
                    end
                end
                PH_MK_FIRST, PH_MK:
                begin
                    app1_next  = (in_byte_reg == BYTE_APP1);
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    lenhi_next = in_byte_reg;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    win_ctrl.clear = 1'b1;
                    if (lenhi_reg == 8'd0 && in_byte_reg < 8'd2)
                    begin
                        // Length below two: search APP1 to end of file, stop on any other marker
                        if (app1_reg)
                        begin
                            open_next  = 1'b1;
                            phase_next = PH_BODY;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                            stop_next  = ST_STOPPED;
                        end
                    end
                    else if (lenhi_reg == 8'd0 && in_byte_reg == 8'd2)
                    begin
                        phase_next = PH_FF;
                    end
                    else
                    begin
                        open_next  = 1'b0;
                        left_next  = {lenhi_reg, in_byte_reg} - 16'd2;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (app1_reg && win_hit)
                    begin
                        phase_next = PH_DONE;
                        stop_next  = ST_FOUND;
                    end
                    else
                    begin
                        win_ctrl.shift = app1_reg;
                        if (!open_reg)
                        begin
                            left_next = left_reg - 16'd1;
                            if (left_reg == 16'd1)
                            begin
                                phase_next = PH_FF;
                            end
                        end
                    end
                end
                PH_DONE:
                begin
                end
                default:
                begin
                    phase_next = PH_DONE;
                    stop_next  = ST_STOPPED;
                end
            endcase

            if (in_last_reg)
            begin
                // Verdict from the state left by this byte
                if (header_early)
                begin
                    status_next = ST_NO_SOI;
                end
                else if (phase_next == PH_DONE)
                begin
                    status_next = stop_next;
                end
                else if (phase_next == PH_BODY && open_next)
                begin
                    status_next = ST_STOPPED;
                end
                else
                begin
                    status_next = ST_NO_MATCH;
                end

                // Return to the reset state for the next file
                phase_next     = PH_SOI0;
                stop_next      = ST_FOUND;
                left_next      = '0;
                lenhi_next     = '0;
                app1_next      = 1'b0;
                open_next      = 1'b0;
                win_ctrl.clear = 1'b1;
                win_ctrl.shift = 1'b0;
            end
        end
    end

    // Scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SOI0;
            stop_reg  <= ST_FOUND;
            left_reg  <= '0;
            lenhi_reg <= '0;
            app1_reg  <= 1'b0;
            open_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            stop_reg  <= stop_next;
            left_reg  <= left_next;
            lenhi_reg <= lenhi_next;
            app1_reg  <= app1_next;
            open_reg  <= open_next;
        end
    end

    // Load the verdict, or drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= proc && in_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && in_last_reg)
        begin
            status_reg <= status_next;
            found_reg  <= (status_next == ST_FOUND);
        end
    end

endmodule

// ===== src/jas_checker.sv =====
// Port-level checks for the JPEG APP1 signature scanner, bound to the top level
`timescale 1ns / 1ps
`include "jpeg_app1_signature_scanner_macros.svh"

module jas_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,   // last
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata    // [0] found, [2:1] status, [7:3] zero
);
    // Hold a stalled verdict
    `JAS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // found is set exactly for the found status
    `JAS_ASSERT_NOW(a_found_status, clk, rst_n, m_tvalid, m_tdata[0] == (m_tdata[2:1] == 2'd0))

    // Keep the padding bits clear
    `JAS_ASSERT_NOW(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[7:3] == 5'd0)

    // A fresh verdict follows an accepted final byte
    `JAS_ASSERT_NOW(a_verdict_src, clk, rst_n, $rose(m_tvalid), $past(s_tvalid && s_tready && s_tlast, 2))

endmodule

bind jpeg_app1_signature_scanner jas_checker u_jas_checker (.*);
